[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the button debouncer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define BDSL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define BDSL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define BDSL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BDSL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/bdsl_pkg.sv]
// Package with the types and constants of the button debouncer.
package bdsl_pkg;

   // Field and register widths.
   localparam int unsigned DEBOUNCE_W = 10;
   localparam int unsigned LONG_W     = 16;
   localparam int unsigned STABLE_W   = 11;
   localparam int unsigned EVENT_W    = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Register reset values.
   localparam logic                  ACTIVE_HIGH_RST    = 1'b1;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_TICKS_RST = 10'd20;
   localparam logic [LONG_W-1:0]     LONG_TICKS_RST     = 16'd1000;

   // Saturation value of the hold counter.
   localparam logic [LONG_W-1:0] HOLD_MAX = 16'hFFFF;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_HIGH    = 2'd0,
      CSR_DEBOUNCE_TICKS = 2'd1,
      CSR_LONG_TICKS     = 2'd2
   } csr_index_type;

   // Event codes of one result item.
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE  = 2'd0,
      EV_SHORT = 2'd1,
      EV_LONG  = 2'd2
   } event_type;

   // Configuration handed to the core.
   typedef struct packed {
      logic                  active_high;
      logic [DEBOUNCE_W-1:0] debounce_ticks;
      logic [LONG_W-1:0]     long_ticks;
   } cfg_type;

   // One result item.
   typedef struct packed {
      event_type event_code;
      logic      debounced_pressed;
   } result_type;

endpackage

[rtl/button_debounce_short_long_press_top.sv]
// Top level of the button debouncer with short and long press events.
// Usage:
// One item on the req channel is one raw pin sample (one tick). Each accepted
// item gives exactly one item on the rsp channel: an event code (none, short
// press on release, long press once per hold) and the debounced state.
// Both channels use valid and stall; an item moves on a rising edge with
// valid high and stall low.
// The result of an accepted item is registered in the rsp register, or in the
// skid register while rsp stalls. Throughput is one item per cycle while rsp
// does not stall, set by the single-pass state update in the core.
// When the receiver stalls, one more item is taken into a skid register and
// then req_stall rises until the rsp side drains.
// Synchronous reset returns the state to released with all counters clear,
// restores the register defaults (active high, debounce 20, long 1000) and
// empties the output registers. The csr port writes one register per cycle;
// the user must write only while the block is idle; the block does not check.
`include "assert_macros.svh"
module button_debounce_short_long_press_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_pin_level,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bdsl_pkg::EVENT_W-1:0]        rsp_event_code,
   output logic                                rsp_debounced_pressed,
   input  logic                                csr_wr_en,
   input  logic [bdsl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bdsl_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import bdsl_pkg::*;

   cfg_type    cfg_ff;
   result_type core_result;
   result_type main_data_ff;
   result_type skid_data_ff;
   logic       main_valid_ff;
   logic       skid_valid_ff;
   logic       req_accept;
   logic       rsp_pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_high    <= ACTIVE_HIGH_RST;
         cfg_ff.debounce_ticks <= DEBOUNCE_TICKS_RST;
         cfg_ff.long_ticks     <= LONG_TICKS_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACTIVE_HIGH: begin
               cfg_ff.active_high <= csr_wr_data[0];
            end
            CSR_DEBOUNCE_TICKS: begin
               cfg_ff.debounce_ticks <= csr_wr_data[DEBOUNCE_W-1:0];
            end
            CSR_LONG_TICKS: begin
               cfg_ff.long_ticks <= csr_wr_data[LONG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Handshakes.
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_pop    = main_valid_ff && !rsp_stall;

   bdsl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .pin_level (req_pin_level),
      .cfg       (cfg_ff),
      .result    (core_result)
   );

   // Output register with a skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || rsp_pop) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Payload of the output and skid registers.
   always_ff @(posedge clock) begin
      if (!main_valid_ff || rsp_pop) begin
         if (skid_valid_ff) begin
            main_data_ff <= skid_data_ff;
         end else if (req_accept) begin
            main_data_ff <= core_result;
         end
      end else if (req_accept) begin
         skid_data_ff <= core_result;
      end
   end

   assign rsp_valid             = main_valid_ff;
   assign rsp_event_code        = main_data_ff.event_code;
   assign rsp_debounced_pressed = main_data_ff.debounced_pressed;

   // A held skid item always has an item in front of it.
   `BDSL_ASSERT_IMP(a_skid_behind_main, clock, reset, skid_valid_ff, main_valid_ff)
   // An item taken while the output is stalled lands in the skid register.
   `BDSL_ASSERT_NEXT(a_stall_fills_skid, clock, reset,
      req_accept && main_valid_ff && rsp_stall, skid_valid_ff)
   // A short press is reported only together with a released state.
   `BDSL_ASSERT_IMP(a_short_released, clock, reset,
      rsp_valid && rsp_event_code == EV_SHORT, !rsp_debounced_pressed)
   // A long press is reported only while pressed.
   `BDSL_ASSERT_IMP(a_long_pressed, clock, reset,
      rsp_valid && rsp_event_code == EV_LONG, rsp_debounced_pressed)

endmodule

[rtl/bdsl_core.sv]
// Debounce and press-timing state with its one-pass update per item.
module bdsl_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 pin_level,
   input  bdsl_pkg::cfg_type    cfg,
   output bdsl_pkg::result_type result
);
   import bdsl_pkg::*;

   logic                last_sample_ff, last_sample_in;
   logic [STABLE_W-1:0] stable_count_ff, stable_count_in;
   logic                committed_ff, committed_in;
   logic [LONG_W-1:0]   hold_count_ff, hold_count_in;
   logic                long_seen_ff, long_seen_in;

   logic                cur;
   logic [STABLE_W-1:0] count_run;
   logic [LONG_W-1:0]   hold_run;
   logic                long_run;
   event_type           ev;

   // Next state and result for the item at the input.
   always_comb begin
      cur            = cfg.active_high ? pin_level : ~pin_level;
      ev             = EV_NONE;
      last_sample_in = last_sample_ff;
      committed_in   = committed_ff;
      hold_run       = hold_count_ff;
      long_run       = long_seen_ff;

      // Count equal samples, restart on a change.
      if (cur == last_sample_ff) begin
         if (stable_count_ff < {1'b0, cfg.debounce_ticks}) begin
            count_run = stable_count_ff + 1'b1;
         end else begin
            count_run = stable_count_ff;
         end
      end else begin
         last_sample_in = cur;
         count_run      = '0;
      end

      // Commit once when the run reaches the threshold.
      stable_count_in = count_run;
      if (count_run == {1'b0, cfg.debounce_ticks}) begin
         if (committed_ff != cur) begin
            committed_in = cur;
            if (!cur && !long_seen_ff) begin
               ev = EV_SHORT;
            end
            hold_run = '0;
            long_run = 1'b0;
         end
         stable_count_in = count_run + 1'b1;
      end

      // Time the hold while pressed.
      hold_count_in = hold_run;
      long_seen_in  = long_run;
      if (committed_in) begin
         if (hold_run < HOLD_MAX) begin
            hold_count_in = hold_run + 1'b1;
         end
         if (hold_count_in >= cfg.long_ticks && !long_run) begin
            long_seen_in = 1'b1;
            ev           = EV_LONG;
         end
      end

      result.event_code        = ev;
      result.debounced_pressed = committed_in;
   end

   // State advances only on an accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff  <= 1'b0;
         stable_count_ff <= '0;
         committed_ff    <= 1'b0;
         hold_count_ff   <= '0;
         long_seen_ff    <= 1'b0;
      end else if (accept) begin
         last_sample_ff  <= last_sample_in;
         stable_count_ff <= stable_count_in;
         committed_ff    <= committed_in;
         hold_count_ff   <= hold_count_in;
         long_seen_ff    <= long_seen_in;
      end
   end

endmodule
